// ----- design/wavhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic REG_CHANNELS = 1'b0;
  localparam logic REG_RATE     = 1'b1;

  localparam logic [15:0] CHANNELS_RESET = 16'd1;
  localparam logic [31:0] RATE_RESET     = 32'd44100;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] FORMAT_PCM = 16'd1;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RIFF     = 3'd1;
  localparam logic [2:0] ERR_WAVE     = 3'd2;
  localparam logic [2:0] ERR_FMT_ID   = 3'd3;
  localparam logic [2:0] ERR_FMT_DATA = 3'd4;

  typedef enum logic [2:0] {
    PH_RIFF_HDR,
    PH_WAVE,
    PH_FMT_HDR,
    PH_FMT_DATA,
    PH_CHUNK,
    PH_SKIP,
    PH_DATA,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] rate;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       in_data;
    logic [2:0] error_code;
  } result_t;

endpackage

// ----- design/wavhp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_in_if / wavhp_out_if
// Valid/ready channels for file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wavhp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       in_data;
  logic [2:0] error_code;

  modport source (output valid, output payload_byte, output payload_valid,
                  output in_data, output error_code, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input in_data, input error_code, output ready);
endinterface

// ----- design/wav_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser
// Streaming RIFF/WAVE header checker that passes out the data chunk bytes.
// ----------------------------------------------------------------------------
// The in channel carries one file byte per beat; the out channel returns one
// result beat per input beat: the byte and a valid flag while inside the data
// chunk, an in_data flag and the latched error code.
// Each accepted byte updates the parser state in the same cycle and its
// result is registered, so a result appears in the cycle after its byte is
// accepted. One byte can be taken every cycle while results are taken; the
// single output register is the only buffer, so in.ready follows the
// emptiness of that register or the taking of its beat by the receiver.
// When the receiver stalls, the result beat holds and input is back-pressured
// after that one beat. After reset the parser expects the RIFF chunk ID, the
// output register is empty, and the configuration registers return to one
// channel and 44100 Hz. Configuration is written through the APB port at
// byte addresses 0 (channels) and 4 (sample rate); the user must write it
// only while the stream is idle, which the block does not enforce. The first
// header error is held until reset and all further bytes only report it.
// ----------------------------------------------------------------------------
module wav_header_parser (
  input  logic                         clk,
  input  logic                         rst,
  wavhp_in_if.sink                     in_ch,
  wavhp_out_if.source                  out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wavhp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  wavhp_pkg::cfg_t    cfg;
  wavhp_pkg::result_t result;
  wavhp_pkg::result_t out_data;
  logic               out_full;
  logic               take;

  assign in_ch.ready = !out_full || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  wavhp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wavhp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (in_ch.data_byte),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

  assign out_ch.valid         = out_full;
  assign out_ch.payload_byte  = out_data.payload_byte;
  assign out_ch.payload_valid = out_data.payload_valid;
  assign out_ch.in_data       = out_data.in_data;
  assign out_ch.error_code    = out_data.error_code;

endmodule

// ----- design/wavhp_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_regs
// APB register file holding the required channel count and sample rate.
// ----------------------------------------------------------------------------
module wavhp_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wavhp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output wavhp_pkg::cfg_t            cfg
);

  logic [15:0] channels;
  logic [31:0] req_rate;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels <= wavhp_pkg::CHANNELS_RESET;
      req_rate <= wavhp_pkg::RATE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        wavhp_pkg::REG_CHANNELS: channels <= pwdata[15:0];
        wavhp_pkg::REG_RATE:     req_rate <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      wavhp_pkg::REG_CHANNELS: prdata = {16'd0, channels};
      wavhp_pkg::REG_RATE:     prdata = req_rate;
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg.channels = channels;
  assign cfg.rate     = req_rate;

endmodule

// ----- design/wavhp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_parser
// Header state machine: assembles words, checks IDs and format data, skips
// unknown chunks and forms the result for each accepted byte.
// ----------------------------------------------------------------------------
module wavhp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  wavhp_pkg::cfg_t    cfg,
  output wavhp_pkg::result_t result
);

  wavhp_pkg::phase_t phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic [31:0] word, word_next;
  logic [31:0] hold, hold_next;
  logic [31:0] skip, skip_next;
  logic [2:0]  err, err_next;
  logic [31:0] word_shift;
  logic [31:0] skip_dec;

  assign word_shift = {data_byte, word[31:8]};
  assign skip_dec   = skip - 32'd1;

  always_comb begin
    phase_next = phase;
    pos_next   = pos + 4'd1;
    word_next  = word;
    hold_next  = hold;
    skip_next  = skip;
    err_next   = err;
    if (phase != wavhp_pkg::PH_DATA && phase != wavhp_pkg::PH_SKIP &&
        phase != wavhp_pkg::PH_ERROR) begin
      word_next = word_shift;
    end
    case (phase)
      wavhp_pkg::PH_RIFF_HDR: begin
        if (pos == 4'd3 && word_shift != wavhp_pkg::ID_RIFF) begin
          err_next   = wavhp_pkg::ERR_RIFF;
          phase_next = wavhp_pkg::PH_ERROR;
          pos_next   = 4'd0;
        end else if (pos == 4'd7) begin
          phase_next = wavhp_pkg::PH_WAVE;
          pos_next   = 4'd0;
        end
      end
      wavhp_pkg::PH_WAVE: begin
        if (pos == 4'd3) begin
          pos_next = 4'd0;
          if (word_shift != wavhp_pkg::ID_WAVE) begin
            err_next   = wavhp_pkg::ERR_WAVE;
            phase_next = wavhp_pkg::PH_ERROR;
          end else begin
            phase_next = wavhp_pkg::PH_FMT_HDR;
          end
        end
      end
      wavhp_pkg::PH_FMT_HDR: begin
        if (pos == 4'd3 && word_shift != wavhp_pkg::ID_FMT) begin
          err_next   = wavhp_pkg::ERR_FMT_ID;
          phase_next = wavhp_pkg::PH_ERROR;
          pos_next   = 4'd0;
        end else if (pos == 4'd7) begin
          phase_next = wavhp_pkg::PH_FMT_DATA;
          pos_next   = 4'd0;
        end
      end
      wavhp_pkg::PH_FMT_DATA: begin
        if (pos == 4'd3) begin
          hold_next = word_shift;
        end
        if (pos == 4'd7 && (hold[15:0] != wavhp_pkg::FORMAT_PCM ||
                            hold[31:16] != cfg.channels ||
                            word_shift != cfg.rate)) begin
          err_next   = wavhp_pkg::ERR_FMT_DATA;
          phase_next = wavhp_pkg::PH_ERROR;
          pos_next   = 4'd0;
        end else if (pos == 4'd15) begin
          phase_next = wavhp_pkg::PH_CHUNK;
          pos_next   = 4'd0;
        end
      end
      wavhp_pkg::PH_CHUNK: begin
        if (pos == 4'd3) begin
          hold_next = word_shift;
        end
        if (pos == 4'd7) begin
          pos_next = 4'd0;
          if (hold == wavhp_pkg::ID_DATA) begin
            phase_next = wavhp_pkg::PH_DATA;
          end else begin
            skip_next  = word_shift;
            phase_next = (word_shift == 32'd0) ? wavhp_pkg::PH_CHUNK
                                               : wavhp_pkg::PH_SKIP;
          end
        end
      end
      wavhp_pkg::PH_SKIP: begin
        skip_next = skip_dec;
        pos_next  = pos;
        if (skip_dec == 32'd0) begin
          phase_next = wavhp_pkg::PH_CHUNK;
          pos_next   = 4'd0;
        end
      end
      default: begin
        pos_next = pos;
      end
    endcase
  end

  always_comb begin
    result.payload_valid = (phase == wavhp_pkg::PH_DATA);
    result.payload_byte  = (phase == wavhp_pkg::PH_DATA) ? data_byte : 8'd0;
    result.in_data       = (phase_next == wavhp_pkg::PH_DATA);
    result.error_code    = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wavhp_pkg::PH_RIFF_HDR;
      pos   <= 4'd0;
      word  <= 32'd0;
      hold  <= 32'd0;
      skip  <= 32'd0;
      err   <= wavhp_pkg::ERR_NONE;
    end else if (take) begin
      phase <= phase_next;
      pos   <= pos_next;
      word  <= word_next;
      hold  <= hold_next;
      skip  <= skip_next;
      err   <= err_next;
    end
  end

endmodule

// ----- tb/wavhp_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhp_stream_checker
// Predicts and checks every result beat of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
// Watches the byte channel, the result channel and the register port. Each
// accepted byte is run through a parser model of its own that tracks the
// header phase, the word being assembled, the skip count and the latched
// error, and the predicted result is queued. Each accepted result beat is
// compared field by field with the oldest prediction. The number of failures
// and the number of outstanding predictions are handed to the top.
// ----------------------------------------------------------------------------
module wavhp_stream_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [7:0]                   out_payload_byte,
  input  logic                         out_payload_valid,
  input  logic                         out_in_data,
  input  logic [2:0]                   out_error_code,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [wavhp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fail_count,
  output int                           pending_count
);

  wavhp_pkg::cfg_t    cfg;
  wavhp_pkg::phase_t  phase;
  logic [3:0]         pos;
  logic [31:0]        word;
  logic [31:0]        hold;
  logic [31:0]        skip;
  logic [2:0]         err;
  wavhp_pkg::result_t expected_results[$];
  int                 mismatches;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    mismatches    = 0;
  end

  function automatic void latch_error(input logic [2:0] code);
    err   = code;
    phase = wavhp_pkg::PH_ERROR;
    pos   = 4'd0;
  endfunction

  function automatic wavhp_pkg::result_t parse_byte(input logic [7:0] b);
    wavhp_pkg::result_t r;
    logic               emit;
    emit = 1'b0;
    if (phase != wavhp_pkg::PH_DATA && phase != wavhp_pkg::PH_SKIP &&
        phase != wavhp_pkg::PH_ERROR) begin
      word = {b, word[31:8]};
    end
    case (phase)
      wavhp_pkg::PH_RIFF_HDR: begin
        if (pos == 4'd3 && word != wavhp_pkg::ID_RIFF) begin
          latch_error(wavhp_pkg::ERR_RIFF);
        end else if (pos == 4'd7) begin
          phase = wavhp_pkg::PH_WAVE;
          pos   = 4'd0;
        end else begin
          pos = pos + 4'd1;
        end
      end
      wavhp_pkg::PH_WAVE: begin
        if (pos == 4'd3) begin
          if (word != wavhp_pkg::ID_WAVE) begin
            latch_error(wavhp_pkg::ERR_WAVE);
          end else begin
            phase = wavhp_pkg::PH_FMT_HDR;
            pos   = 4'd0;
          end
        end else begin
          pos = pos + 4'd1;
        end
      end
      wavhp_pkg::PH_FMT_HDR: begin
        if (pos == 4'd3 && word != wavhp_pkg::ID_FMT) begin
          latch_error(wavhp_pkg::ERR_FMT_ID);
        end else if (pos == 4'd7) begin
          phase = wavhp_pkg::PH_FMT_DATA;
          pos   = 4'd0;
        end else begin
          pos = pos + 4'd1;
        end
      end
      wavhp_pkg::PH_FMT_DATA: begin
        if (pos == 4'd3) begin
          hold = word;
        end
        if (pos == 4'd7 && (hold[15:0] != wavhp_pkg::FORMAT_PCM ||
                            hold[31:16] != cfg.channels ||
                            word != cfg.rate)) begin
          latch_error(wavhp_pkg::ERR_FMT_DATA);
        end else if (pos == 4'd15) begin
          phase = wavhp_pkg::PH_CHUNK;
          pos   = 4'd0;
        end else begin
          pos = pos + 4'd1;
        end
      end
      wavhp_pkg::PH_CHUNK: begin
        if (pos == 4'd3) begin
          hold = word;
        end
        if (pos == 4'd7) begin
          pos = 4'd0;
          if (hold == wavhp_pkg::ID_DATA) begin
            phase = wavhp_pkg::PH_DATA;
          end else begin
            skip  = word;
            phase = (word == 32'd0) ? wavhp_pkg::PH_CHUNK : wavhp_pkg::PH_SKIP;
          end
        end else begin
          pos = pos + 4'd1;
        end
      end
      wavhp_pkg::PH_SKIP: begin
        skip = skip - 32'd1;
        if (skip == 32'd0) begin
          phase = wavhp_pkg::PH_CHUNK;
          pos   = 4'd0;
        end
      end
      wavhp_pkg::PH_DATA: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    r.payload_byte  = emit ? b : 8'd0;
    r.payload_valid = emit;
    r.in_data       = (phase == wavhp_pkg::PH_DATA);
    r.error_code    = err;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    wavhp_pkg::result_t want;
    if (rst) begin
      cfg.channels = wavhp_pkg::CHANNELS_RESET;
      cfg.rate     = wavhp_pkg::RATE_RESET;
      phase        = wavhp_pkg::PH_RIFF_HDR;
      pos          = 4'd0;
      word         = 32'd0;
      hold         = 32'd0;
      skip         = 32'd0;
      err          = wavhp_pkg::ERR_NONE;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[wavhp_pkg::ADDR_W-1] == wavhp_pkg::REG_CHANNELS) begin
          cfg.channels = pwdata[15:0];
        end else begin
          cfg.rate = pwdata;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(parse_byte(in_data_byte));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with no byte pending", $realtime);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
          check_field("payload_valid", 32'(want.payload_valid), 32'(out_payload_valid));
          check_field("in_data", 32'(want.in_data), 32'(out_in_data));
          check_field("error_code", 32'(want.error_code), 32'(out_error_code));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

// ----- tb/wav_header_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser_test
// Stream-level test of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
// Builds one WAV file as a byte stream: a header that matches the configured
// channel count and sample rate (or, in some runs, carries a single fault in
// an ID, the tag or the format data), a series of chunks to skip with zero,
// small and long sizes, the data chunk and a long random payload. The stream
// is sent in four phases with different idle and stall rates on the two
// channels; between phases the stream drains and both registers are written
// with new values, extremes among them. A separate checker predicts every
// result beat and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module wav_header_parser_test;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    FAULT_NONE,
    FAULT_RIFF,
    FAULT_WAVE,
    FAULT_FMT_ID,
    FAULT_FORMAT,
    FAULT_CHANNELS,
    FAULT_RATE
  } fault_t;

  typedef enum int {
    CFG_RESET,
    CFG_ZERO,
    CFG_MAX,
    CFG_RANDOM
  } cfg_mode_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [wavhp_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  int                           fail_count;
  int                           pending_count;
  int                           cycle_count = 0;
  int unsigned                  idle_pct = 0;
  int unsigned                  stall_pct = 0;
  logic [7:0]                   file_bytes[$];

  wavhp_in_if  in_ch ();
  wavhp_out_if out_ch ();

  wav_header_parser dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wavhp_stream_checker stream_chk (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_byte      (in_ch.data_byte),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_payload_byte  (out_ch.payload_byte),
    .out_payload_valid (out_ch.payload_valid),
    .out_in_data       (out_ch.in_data),
    .out_error_code    (out_ch.error_code),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [31:0] flip_bit(input logic [31:0] w, input int unsigned width);
    return w ^ (32'd1 << $urandom_range(width - 1));
  endfunction

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      file_bytes.push_back(w[8*i +: 8]);
    end
  endtask

  task automatic push_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      file_bytes.push_back(8'($urandom()));
    end
  endtask

  task automatic push_chunk(input logic [31:0] id, input logic [31:0] size);
    push_word(id);
    push_word(size);
    push_noise(size);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic reg_write(input logic reg_index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_stream();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    fault_t      fault;
    cfg_mode_t   cfg_mode;
    logic [15:0] chan;
    logic [31:0] rate;
    logic [15:0] fmt_code;
    logic [31:0] id;
    int unsigned total;
    int unsigned first;
    int unsigned last;

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'd0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= 32'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fault    = ($urandom_range(4) == 0) ? fault_t'($urandom_range(1, 6)) : FAULT_NONE;
    cfg_mode = cfg_mode_t'($urandom_range(3));
    case (cfg_mode)
      CFG_ZERO: begin
        chan = 16'd0;
        rate = 32'd0;
      end
      CFG_MAX: begin
        chan = 16'hFFFF;
        rate = 32'hFFFF_FFFF;
      end
      CFG_RANDOM: begin
        chan = 16'($urandom());
        rate = $urandom();
      end
      default: begin
        chan = wavhp_pkg::CHANNELS_RESET;
        rate = wavhp_pkg::RATE_RESET;
      end
    endcase
    if (cfg_mode != CFG_RESET) begin
      reg_write(wavhp_pkg::REG_CHANNELS, {16'd0, chan});
      reg_write(wavhp_pkg::REG_RATE, rate);
    end

    // Header, with at most one fault planted in it.
    fmt_code = ($urandom_range(1) == 0) ? 16'd0
                                        : 16'(flip_bit({16'd0, wavhp_pkg::FORMAT_PCM}, 16));
    push_word((fault == FAULT_RIFF) ? flip_bit(wavhp_pkg::ID_RIFF, 32) : wavhp_pkg::ID_RIFF);
    push_word($urandom());
    push_word((fault == FAULT_WAVE) ? flip_bit(wavhp_pkg::ID_WAVE, 32) : wavhp_pkg::ID_WAVE);
    push_word((fault == FAULT_FMT_ID) ? flip_bit(wavhp_pkg::ID_FMT, 32) : wavhp_pkg::ID_FMT);
    push_word($urandom());
    push_word({(fault == FAULT_CHANNELS) ? 16'(flip_bit({16'd0, chan}, 16)) : chan,
               (fault == FAULT_FORMAT) ? fmt_code : wavhp_pkg::FORMAT_PCM});
    push_word((fault == FAULT_RATE) ? flip_bit(rate, 32) : rate);
    push_word($urandom());
    push_word($urandom());

    // Chunks to skip: empty, one byte, a near miss of the data ID, a body
    // that holds the data ID, and one long enough to need bit 8 of the size.
    push_chunk($urandom(), 32'd0);
    push_chunk(flip_bit(wavhp_pkg::ID_DATA, 32), 32'd1);
    push_word($urandom());
    push_word(32'd8);
    push_word(wavhp_pkg::ID_DATA);
    push_word(wavhp_pkg::ID_DATA);
    push_chunk(~wavhp_pkg::ID_DATA, 32'd256 + $urandom_range(31));
    while (file_bytes.size() < 700) begin
      id = $urandom();
      if (id == wavhp_pkg::ID_DATA) begin
        id = ~id;
      end
      push_chunk(id, ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(24));
    end

    // Data chunk: its size is ignored and everything after it is payload.
    push_word(wavhp_pkg::ID_DATA);
    push_word($urandom());
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word(wavhp_pkg::ID_RIFF);
    push_noise(640);

    total = file_bytes.size();
    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        drain_stream();
        case (p)
          1: begin
            reg_write(wavhp_pkg::REG_CHANNELS, 32'h0000_FFFF);
            reg_write(wavhp_pkg::REG_RATE, 32'hFFFF_FFFF);
          end
          2: begin
            reg_write(wavhp_pkg::REG_CHANNELS, 32'd0);
            reg_write(wavhp_pkg::REG_RATE, 32'd0);
          end
          default: begin
            reg_write(wavhp_pkg::REG_CHANNELS, $urandom());
            reg_write(wavhp_pkg::REG_RATE, $urandom());
          end
        endcase
      end
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct  = 28;
          stall_pct = 28;
        end
      endcase
      first = total * p / 4;
      last  = total * (p + 1) / 4;
      for (int unsigned i = first; i < last; i++) begin
        send_byte(file_bytes[i]);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
